// ----- src/fha_pkg.sv -----
package fha_pkg;

   localparam int FREE_ENTRIES_DEF = 16;
   localparam int USED_ENTRIES_DEF = 16;
   localparam int ADDR_BITS_DEF    = 11;
   localparam int TAG_BITS_DEF     = 8;
   localparam int OUT_BITS         = 11;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_NEXT  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FIT  = 2'd1;
   localparam logic [1:0] ST_NO_TAG  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int RESET_BLOCKS = 4;
   localparam int RST_START [RESET_BLOCKS] = '{0, 500, 1250, 1600};
   localparam int RST_LEN   [RESET_BLOCKS] = '{500, 750, 350, 400};

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_DONE
   } state_type;

   // ring operation that all cells of one ring apply together
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ROT
   } op_type;

endpackage

// ----- src/fha_free_cell.sv -----
module fha_free_cell import fha_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int RST_IDX   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic                 prev_live,
   input  logic [ADDR_BITS-1:0] prev_start,
   input  logic [ADDR_BITS-1:0] prev_len,
   output logic                 live,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS-1:0] len
);

   logic                 live_ff, live_in;
   logic [ADDR_BITS-1:0] start_ff, start_in, len_ff, len_in;

   always_comb begin
      live_in  = live_ff;
      start_in = start_ff;
      len_in   = len_ff;
      case (op)
         OP_ROT: begin
            live_in  = prev_live;
            start_in = prev_start;
            len_in   = prev_len;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= (RST_IDX < RESET_BLOCKS);
         start_ff <= (RST_IDX < RESET_BLOCKS) ? ADDR_BITS'(RST_START[RST_IDX % RESET_BLOCKS])
                                               : '0;
         len_ff <= (RST_IDX < RESET_BLOCKS) ? ADDR_BITS'(RST_LEN[RST_IDX % RESET_BLOCKS]) : '0;
      end else begin
         live_ff  <= live_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   assign live  = live_ff;
   assign start = start_ff;
   assign len   = len_ff;

endmodule

// ----- src/fha_used_cell.sv -----
module fha_used_cell import fha_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic                 prev_live,
   input  logic [TAG_BITS-1:0]  prev_tag,
   input  logic [ADDR_BITS-1:0] prev_start,
   input  logic [ADDR_BITS-1:0] prev_len,
   output logic                 live,
   output logic [TAG_BITS-1:0]  tag,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS-1:0] len
);

   logic                 live_ff, live_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [ADDR_BITS-1:0] start_ff, start_in, len_ff, len_in;

   always_comb begin
      live_in  = live_ff;
      tag_in   = tag_ff;
      start_in = start_ff;
      len_in   = len_ff;
      case (op)
         OP_ROT: begin
            live_in  = prev_live;
            tag_in   = prev_tag;
            start_in = prev_start;
            len_in   = prev_len;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign live  = live_ff;
   assign tag   = tag_ff;
   assign start = start_ff;
   assign len   = len_ff;

endmodule

// ----- src/fit_heap_allocator.sv -----
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_cmd, req_fit_mode, req_req_size, req_tag
// rsp     | out | rsp_valid/rsp_ready  | rsp_status, rsp_block_addr, rsp_block_len
// Both tables are rings of cells that rotate one place a cycle during a scan or shift pass;
// slot 0 is the head. A request runs a scan pass (one full rotation), a decide step,
// a shift pass (one full rotation that deletes or inserts in order), then the result.
// Reset (synchronous) loads the four initial free blocks at once; no clearing pass.
// A result held by rsp_ready keeps the block in its last state; the next request waits.
module fit_heap_allocator import fha_pkg::*; #(
   parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = USED_ENTRIES_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF,
   parameter int TAG_BITS     = TAG_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [1:0]           req_fit_mode,
   input  logic [ADDR_BITS-1:0] req_req_size,
   input  logic [TAG_BITS-1:0]  req_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [OUT_BITS-1:0]  rsp_block_addr,
   output logic [OUT_BITS-1:0]  rsp_block_len
);

   localparam int NMAX = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int CW   = $clog2(NMAX + 1);
   localparam int FW   = $clog2(FREE_ENTRIES + 1);
   localparam int UW   = $clog2(USED_ENTRIES + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic                 cmd_ff;
   logic [1:0]           mode_ff;
   logic [ADDR_BITS-1:0] size_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [ADDR_BITS-1:0] hw_ff;

   // scan results
   logic                 fpick_ff;
   logic [FW-1:0]        fidx_ff;
   logic [ADDR_BITS-1:0] fstart_ff, flen_ff;
   logic                 uhit_ff;
   logic [UW-1:0]        uidx_ff;
   logic [ADDR_BITS-1:0] ustart_ff, ulen_ff;
   logic [FW-1:0]        nf_ff;
   logic [UW-1:0]        nu_ff;

   // decision
   logic [1:0]           st_ff;
   logic                 fdo_ff, udo_ff;       // touch table
   logic                 frem_ff, urem_ff;     // remove (else insert/update)
   logic                 fins_ff;              // free insert of a new entry
   logic [ADDR_BITS-1:0] fnstart_ff, fnlen_ff;
   logic [ADDR_BITS-1:0] oaddr_ff, olen_ff;

   // carry that rides along the ring during an ordered insert
   logic                 fc_live_ff, uc_live_ff;
   logic [ADDR_BITS-1:0] fc_start_ff, fc_len_ff, uc_start_ff, uc_len_ff;
   logic [TAG_BITS-1:0]  uc_tag_ff;
   logic                 fdone_ff, udone_ff;   // insert already placed this pass

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [OUT_BITS-1:0]  rsp_addr_ff, rsp_len_ff;

   op_type f_op, u_op;

   logic                 f_live [FREE_ENTRIES];
   logic [ADDR_BITS-1:0] f_start [FREE_ENTRIES];
   logic [ADDR_BITS-1:0] f_len [FREE_ENTRIES];
   logic                 u_live [USED_ENTRIES];
   logic [TAG_BITS-1:0]  u_tag [USED_ENTRIES];
   logic [ADDR_BITS-1:0] u_start [USED_ENTRIES];
   logic [ADDR_BITS-1:0] u_len [USED_ENTRIES];

   // value written into the tail cell on a rotation
   logic                 ft_live, ut_live;
   logic [ADDR_BITS-1:0] ft_start, ft_len, ut_start, ut_len;
   logic [TAG_BITS-1:0]  ut_tag;

   // ring: cell i takes from cell i+1, the tail takes the tail value
   for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_free
      localparam int P = (i + 1) % FREE_ENTRIES;
      localparam bit TAIL = (i == FREE_ENTRIES - 1);
      fha_free_cell #(.ADDR_BITS(ADDR_BITS), .RST_IDX(i)) u_cell (
         .clock, .reset, .op(f_op),
         .prev_live(TAIL ? ft_live : f_live[P]),
         .prev_start(TAIL ? ft_start : f_start[P]),
         .prev_len(TAIL ? ft_len : f_len[P]),
         .live(f_live[i]), .start(f_start[i]), .len(f_len[i]));
   end

   for (genvar i = 0; i < USED_ENTRIES; i++) begin : g_used
      localparam int P = (i + 1) % USED_ENTRIES;
      localparam bit TAIL = (i == USED_ENTRIES - 1);
      fha_used_cell #(.ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS)) u_cell (
         .clock, .reset, .op(u_op),
         .prev_live(TAIL ? ut_live : u_live[P]),
         .prev_tag(TAIL ? ut_tag : u_tag[P]),
         .prev_start(TAIL ? ut_start : u_start[P]),
         .prev_len(TAIL ? ut_len : u_len[P]),
         .live(u_live[i]), .tag(u_tag[i]), .start(u_start[i]), .len(u_len[i]));
   end

   // head views
   logic                 fh_live, uh_live;
   logic [ADDR_BITS-1:0] fh_start, fh_len, uh_start, uh_len;
   logic [TAG_BITS-1:0]  uh_tag;
   assign fh_live  = f_live[0];
   assign fh_start = f_start[0];
   assign fh_len   = f_len[0];
   assign uh_live  = u_live[0];
   assign uh_tag   = u_tag[0];
   assign uh_start = u_start[0];
   assign uh_len   = u_len[0];

   logic f_rot_now, u_rot_now;
   assign f_rot_now = (cnt_ff < CW'(FREE_ENTRIES));
   assign u_rot_now = (cnt_ff < CW'(USED_ENTRIES));

   // head index during a pass equals cnt (ring returns to place after depth steps)
   logic [FW-1:0] fpos;
   logic [UW-1:0] upos;
   logic          f_last, u_last;
   assign fpos   = FW'(cnt_ff);
   assign upos   = UW'(cnt_ff);
   assign f_last = (fpos == FW'(FREE_ENTRIES - 1));
   assign u_last = (upos == UW'(USED_ENTRIES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NMAX - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_SHIFT;
            cnt_in   = '0;
         end
         S_SHIFT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NMAX - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs to the rings
   always_comb begin
      f_op = OP_HOLD;
      u_op = OP_HOLD;
      unique case (state_ff)
         S_SCAN, S_SHIFT: begin
            if (f_rot_now) f_op = OP_ROT;
            if (u_rot_now) u_op = OP_ROT;
         end
         default: ;
      endcase
   end

   // insert position: first live entry with start >= new start, or first dead one
   logic f_here, u_here;
   assign f_here = fins_ff && !fdone_ff && (!fh_live || !(fh_start < fnstart_ff));
   assign u_here = !urem_ff && !udone_ff && (!uh_live || !(uh_start < oaddr_ff));

   // what the tail gets at pass position k becomes entry k after the pass
   always_comb begin
      ft_live = fh_live; ft_start = fh_start; ft_len = fh_len;
      if (state_ff == S_SHIFT && fdo_ff) begin
         if (frem_ff) begin
            if (!(fpos < fidx_ff)) begin
               ft_live = f_last ? 1'b0 : f_live[1];
               ft_start = f_start[1]; ft_len = f_len[1];
            end
         end else if (fins_ff) begin
            if (f_here || fdone_ff) begin
               ft_live = fc_live_ff; ft_start = fc_start_ff; ft_len = fc_len_ff;
            end
         end else if (fpos == fidx_ff) begin
            ft_start = fnstart_ff; ft_len = fnlen_ff;
         end
      end
   end

   always_comb begin
      ut_live = uh_live; ut_tag = uh_tag; ut_start = uh_start; ut_len = uh_len;
      if (state_ff == S_SHIFT && udo_ff) begin
         if (urem_ff) begin
            if (!(upos < uidx_ff)) begin
               ut_live = u_last ? 1'b0 : u_live[1]; ut_tag = u_tag[1];
               ut_start = u_start[1]; ut_len = u_len[1];
            end
         end else if (u_here || udone_ff) begin
            ut_live = uc_live_ff; ut_tag = uc_tag_ff;
            ut_start = uc_start_ff; ut_len = uc_len_ff;
         end
      end
   end

   // scan
   logic [FW-1:0] f_cnt_live;
   logic [UW-1:0] u_cnt_live;
   always_comb begin
      f_cnt_live = '0;
      u_cnt_live = '0;
      for (int i = 0; i < FREE_ENTRIES; i++) f_cnt_live += FW'(f_live[i]);
      for (int i = 0; i < USED_ENTRIES; i++) u_cnt_live += UW'(u_live[i]);
   end

   logic fit;
   assign fit = fh_live && !(fh_len < size_ff);

   // free table is address ordered, so next fit is the first fit at or above hw
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff  <= req_cmd;
         mode_ff <= req_fit_mode;
         size_ff <= req_req_size;
         tag_ff  <= req_tag;
         fpick_ff <= 1'b0;
         uhit_ff  <= 1'b0;
         nf_ff <= f_cnt_live;
         nu_ff <= u_cnt_live;
      end else if (state_ff == S_SCAN) begin
         if (f_rot_now && fit) begin
            if (mode_ff == MODE_BEST) begin
               if (!fpick_ff || fh_len < flen_ff) begin
                  fpick_ff <= 1'b1; fidx_ff <= fpos;
                  fstart_ff <= fh_start; flen_ff <= fh_len;
               end
            end else if (!fpick_ff && (mode_ff != MODE_NEXT || !(fh_start < hw_ff))) begin
               fpick_ff <= 1'b1; fidx_ff <= fpos;
               fstart_ff <= fh_start; flen_ff <= fh_len;
            end
         end
         if (u_rot_now && uh_live && !uhit_ff && uh_tag == tag_ff) begin
            uhit_ff <= 1'b1; uidx_ff <= upos;
            ustart_ff <= uh_start; ulen_ff <= uh_len;
         end
      end
   end

   // decide
   logic [1:0]           d_st;
   logic                 d_fdo, d_udo, d_frem, d_urem, d_fins;
   logic [ADDR_BITS-1:0] d_fns, d_fnl, d_oa, d_ol;
   always_comb begin
      d_st = ST_OK; d_fdo = 1'b0; d_udo = 1'b0; d_frem = 1'b0; d_urem = 1'b0;
      d_fins = 1'b0; d_fns = fstart_ff + size_ff; d_fnl = flen_ff - size_ff;
      d_oa = '0; d_ol = '0;
      if (cmd_ff == CMD_ALLOC) begin
         if (nu_ff == UW'(USED_ENTRIES)) begin
            d_st = ST_FULL;
         end else if (size_ff == '0 || !fpick_ff) begin
            d_st = ST_NO_FIT;
         end else begin
            d_fdo = 1'b1; d_udo = 1'b1;
            d_frem = (flen_ff == size_ff);
            d_oa = fstart_ff; d_ol = size_ff;
         end
      end else begin
         if (!uhit_ff) begin
            d_st = ST_NO_TAG;
         end else if (nf_ff == FW'(FREE_ENTRIES)) begin
            d_st = ST_FULL;
         end else begin
            d_fdo = 1'b1; d_udo = 1'b1; d_urem = 1'b1; d_fins = 1'b1;
            d_fns = ustart_ff; d_fnl = ulen_ff;
            d_oa = ustart_ff; d_ol = ulen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= '0;
      end else if (state_ff == S_DECIDE && cmd_ff == CMD_ALLOC && d_st == ST_OK) begin
         if (hw_ff < d_fns) hw_ff <= d_fns;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DECIDE) begin
         st_ff <= d_st; fdo_ff <= d_fdo; udo_ff <= d_udo;
         frem_ff <= d_frem; urem_ff <= d_urem; fins_ff <= d_fins;
         fnstart_ff <= d_fns; fnlen_ff <= d_fnl;
         oaddr_ff <= d_oa; olen_ff <= d_ol;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DECIDE) begin
         fc_live_ff <= 1'b1; fc_start_ff <= d_fns; fc_len_ff <= d_fnl;
         uc_live_ff <= 1'b1; uc_tag_ff <= tag_ff;
         uc_start_ff <= d_oa; uc_len_ff <= d_ol;
         fdone_ff <= 1'b0; udone_ff <= 1'b0;
      end else if (state_ff == S_SHIFT) begin
         if (f_rot_now && fdo_ff && fins_ff && (f_here || fdone_ff)) begin
            fc_live_ff <= fh_live; fc_start_ff <= fh_start; fc_len_ff <= fh_len;
            fdone_ff <= 1'b1;
         end
         if (u_rot_now && udo_ff && !urem_ff && (u_here || udone_ff)) begin
            uc_live_ff <= uh_live; uc_tag_ff <= uh_tag;
            uc_start_ff <= uh_start; uc_len_ff <= uh_len;
            udone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= st_ff;
         rsp_addr_ff   <= OUT_BITS'(oaddr_ff);
         rsp_len_ff    <= OUT_BITS'(olen_ff);
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_block_len  = rsp_len_ff;

endmodule

// ----- src/fha_checker.sv -----
module fha_checker import fha_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [10:0] rsp_block_addr,
   input logic [10:0] rsp_block_len
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_addr == '0 && rsp_block_len == '0)
      else $error("error result carries a block");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_block_len != '0)
      else $error("ok result with empty block");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken at once");

endmodule

bind fit_heap_allocator fha_checker u_fha_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_block_addr, .rsp_block_len
);

// ----- test/fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps

module fit_heap_allocator_tb import fha_pkg::*; ();

   localparam int NFREE = 16;
   localparam int NUSED = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]  status;
      logic [10:0] addr;
      logic [10:0] len;
   } alloc_result_type;

   class heap_scoreboard;
      logic [10:0] fr_start [NFREE];
      logic [10:0] fr_len [NFREE];
      int          fr_count;
      logic [7:0]  us_tag [NUSED];
      logic [10:0] us_start [NUSED];
      logic [10:0] us_len [NUSED];
      int          us_count;
      logic [10:0] high_mark;
      alloc_result_type pending[$];
      int          errors;

      function new();
         for (int i = 0; i < NFREE; i++) begin
            fr_start[i] = 0;
            fr_len[i] = 0;
         end
         for (int i = 0; i < RESET_BLOCKS; i++) begin
            fr_start[i] = 11'(RST_START[i]);
            fr_len[i] = 11'(RST_LEN[i]);
         end
         fr_count = RESET_BLOCKS;
         us_count = 0;
         high_mark = 0;
         errors = 0;
      endfunction

      function void note_request(logic cmd, logic [1:0] mode, logic [10:0] size,
                                 logic [7:0] tag);
         alloc_result_type r;
         int pick;
         int pos;
         logic [10:0] fin;
         r.status = ST_OK;
         r.addr = 0;
         r.len = 0;
         pick = -1;
         if (cmd == CMD_ALLOC) begin
            if (us_count >= NUSED) r.status = ST_FULL;
            else if (size == 0) r.status = ST_NO_FIT;
            else begin
               if (mode == MODE_BEST) begin
                  for (int i = 0; i < fr_count; i++)
                     if (fr_len[i] >= size && (pick < 0 || fr_len[i] < fr_len[pick]))
                        pick = i;
               end else begin
                  pos = 0;
                  if (mode == MODE_NEXT)
                     while (pos < fr_count && fr_start[pos] < high_mark) pos++;
                  for (int i = pos; i < fr_count; i++)
                     if (pick < 0 && fr_len[i] >= size) pick = i;
               end
               if (pick < 0) r.status = ST_NO_FIT;
               else begin
                  r.addr = fr_start[pick];
                  r.len = size;
                  if (fr_len[pick] == size) begin
                     for (int i = pick; i + 1 < fr_count; i++) begin
                        fr_start[i] = fr_start[i+1];
                        fr_len[i] = fr_len[i+1];
                     end
                     fr_count--;
                  end else begin
                     fr_start[pick] = fr_start[pick] + size;
                     fr_len[pick] = fr_len[pick] - size;
                  end
                  fin = r.addr + size;
                  if (fin > high_mark) high_mark = fin;
                  pos = 0;
                  while (pos < us_count && us_start[pos] < r.addr) pos++;
                  for (int i = us_count; i > pos; i--) begin
                     us_tag[i] = us_tag[i-1];
                     us_start[i] = us_start[i-1];
                     us_len[i] = us_len[i-1];
                  end
                  us_tag[pos] = tag;
                  us_start[pos] = r.addr;
                  us_len[pos] = size;
                  us_count++;
               end
            end
         end else begin
            for (int i = 0; i < us_count; i++)
               if (pick < 0 && us_tag[i] == tag) pick = i;
            if (pick < 0) r.status = ST_NO_TAG;
            else if (fr_count >= NFREE) r.status = ST_FULL;
            else begin
               r.addr = us_start[pick];
               r.len = us_len[pick];
               for (int i = pick; i + 1 < us_count; i++) begin
                  us_tag[i] = us_tag[i+1];
                  us_start[i] = us_start[i+1];
                  us_len[i] = us_len[i+1];
               end
               us_count--;
               pos = 0;
               while (pos < fr_count && fr_start[pos] < r.addr) pos++;
               for (int i = fr_count; i > pos; i--) begin
                  fr_start[i] = fr_start[i-1];
                  fr_len[i] = fr_len[i-1];
               end
               fr_start[pos] = r.addr;
               fr_len[pos] = r.len;
               fr_count++;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [10:0] addr, logic [10:0] len);
         alloc_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected transfer: status %0d addr %0d len %0d", status, addr, len);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (addr !== e.addr) begin
            $error("block_addr: expected %0d, actual %0d", e.addr, addr);
            errors++;
         end
         if (len !== e.len) begin
            $error("block_len: expected %0d, actual %0d", e.len, len);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [1:0]  req_fit_mode;
   logic [10:0] req_req_size;
   logic [7:0]  req_tag;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_block_addr;
   logic [10:0] rsp_block_len;

   heap_scoreboard heap = new();
   bit  calm;
   bit  hold_rsp;
   int  cycles;

   fit_heap_allocator dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send(logic cmd, logic [1:0] mode, logic [10:0] size, logic [7:0] tag);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_fit_mode <= mode;
      req_req_size <= size;
      req_tag <= tag;
      do @(posedge clock); while (!req_ready);
      heap.note_request(cmd, mode, size, tag);
   endtask

   task automatic send_random();
      logic [10:0] size;
      case ($urandom_range(0, 9))
         0: size = 11'($urandom_range(0, 2047));
         1: size = 11'd0;
         2: size = 11'($urandom_range(300, 800));
         default: size = 11'($urandom_range(1, 150));
      endcase
      send($urandom_range(0, 9) < 5 ? CMD_ALLOC : CMD_FREE, 2'($urandom_range(0, 3)), size,
           $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 15)) : 8'($urandom));
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_rsp) rsp_ready <= 0;
      else if (calm) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
      if (!reset && rsp_valid && rsp_ready)
         heap.check_result(rsp_status, rsp_block_addr, rsp_block_len);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fit_heap_allocator: mismatch");
         $finish;
      end
   end

   initial begin
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp <= 0;
   end

   initial begin
      cycles = 0;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_cmd = 0;
      req_fit_mode = 0;
      req_req_size = 0;
      req_tag = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      send(CMD_ALLOC, MODE_FIRST, 11'd0, 8'd1);
      send(CMD_ALLOC, MODE_FIRST, 11'd2047, 8'd2);
      send(CMD_ALLOC, MODE_BEST, 11'd350, 8'hff);
      send(CMD_ALLOC, MODE_NEXT, 11'd100, 8'h00);
      send(CMD_ALLOC, 2'd3, 11'd500, 8'haa);
      send(CMD_ALLOC, MODE_BEST, 11'd1, 8'h55);
      send(CMD_ALLOC, MODE_NEXT, 11'd1, 8'h55);
      send(CMD_FREE, MODE_FIRST, 11'h7ff, 8'h55);
      send(CMD_FREE, MODE_FIRST, 11'd0, 8'h77);
      send(CMD_FREE, MODE_FIRST, 11'd0, 8'hff);
      send(CMD_ALLOC, MODE_NEXT, 11'd2000, 8'd3);
      for (int i = 0; i < 17; i++) send(CMD_ALLOC, i[1:0], 11'd5, 8'(i));
      for (int i = 0; i < 16; i++) send(CMD_FREE, MODE_FIRST, 11'd1, 8'(i));
      for (int i = 0; i < 460; i++) begin
         if (i == 400) calm <= 1;
         send_random();
      end
      req_valid <= 0;
      while (heap.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (heap.errors == 0 && heap.pending.size() == 0)
         $display("fit_heap_allocator: match");
      else
         $display("fit_heap_allocator: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
src/fha_pkg.sv
src/fha_free_cell.sv
src/fha_used_cell.sv
src/fit_heap_allocator.sv
src/fha_checker.sv
test/fit_heap_allocator_tb.sv
